>>> rtl/fbpa_pkg.sv
// Shared types and codes for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

   // Request kinds carried on req_tuser
   typedef logic [1:0] req_kind_type;
   localparam req_kind_type REQ_REBUILD = 2'd0;
   localparam req_kind_type REQ_ALLOC   = 2'd1;
   localparam req_kind_type REQ_FREE    = 2'd2;

   // Result status codes carried on rsp_tuser
   typedef logic [2:0] status_type;
   localparam status_type ST_OK    = 3'd0;
   localparam status_type ST_EMPTY = 3'd1;
   localparam status_type ST_SIZE  = 3'd2;
   localparam status_type ST_ALIGN = 3'd3;
   localparam status_type ST_ADDR  = 3'd4;

   // Register indexes on the csr port
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_REGION_BASE = 2'd0;
   localparam csr_index_type CSR_REGION_SIZE = 2'd1;
   localparam csr_index_type CSR_BLOCK_SIZE  = 2'd2;
   localparam csr_index_type CSR_BLOCK_ALIGN = 2'd3;

   // Jobs run on the shared divider
   typedef logic [2:0] div_job_type;
   localparam div_job_type JOB_STRIDE = 3'd0;
   localparam div_job_type JOB_BASE   = 3'd1;
   localparam div_job_type JOB_COUNT  = 3'd2;
   localparam div_job_type JOB_OFF    = 3'd3;
   localparam div_job_type JOB_ALIGN  = 3'd4;

   // Divider widths: 33-bit dividend, 17-bit divisor
   localparam int DVW       = 33;
   localparam int DSW       = 17;
   localparam int DIV_STEPS = 33;

endpackage

>>> rtl/fixed_block_pool_allocator_core.sv
// Fixed block pool allocator: free list kept in a link memory.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser kind, tdata size/align/address
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser status, tdata grant/bytes/count
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// One item at a time; the steps below run from acceptance until the next item can be taken.
// Allocate reads the link, then multiplies and adds; a refused one goes straight to its result.
// Free answers straight away on a size or alignment error, after the range check outside the
// pool, else after one or two runs of the bit-serial divider (offset by stride, address by
// alignment); a refused address ends there, else the block is pushed.
// Rebuild takes two or three divider runs plus one link write per block.
// Reset empties the pool; no clearing pass. A stalled result holds in the output
// register; the next item is taken and its result waits until the register frees.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_core #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [63:0]                  req_tdata,  // req_size, req_align, free_address
   input  fbpa_pkg::req_kind_type       req_tuser,  // req_type
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [63:0]                  rsp_tdata,  // grant_address, grant_bytes, block_count
   output fbpa_pkg::status_type         rsp_tuser,  // status
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  fbpa_pkg::csr_index_type      csr_index,
   input  logic [31:0]                  csr_data
);
   import fbpa_pkg::*;

   localparam int IW   = $clog2(MAX_BLOCKS + 1);
   localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int MW   = DSW + IW;
   localparam int CMPW = (MW > 32) ? MW : 32;
   localparam logic [IW-1:0] NULL_IDX = IW'(MAX_BLOCKS);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_DIV      = 4'd2;
   localparam logic [3:0] S_RB_LINK  = 4'd3;
   localparam logic [3:0] S_AL_WAIT  = 4'd4;
   localparam logic [3:0] S_AL_ADD   = 4'd5;
   localparam logic [3:0] S_FR_CHECK = 4'd6;
   localparam logic [3:0] S_FR_PUSH  = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   logic [3:0]        state_ff, state_in;

   // configuration
   logic [31:0]       cfg_base_ff;
   logic [24:0]       cfg_rsize_ff;
   logic [15:0]       cfg_bsize_ff;
   logic [12:0]       cfg_balign_ff;

   // pool state
   logic [IW-1:0]     head_ff;
   logic [IW-1:0]     total_ff;
   logic [31:0]       first_ff;
   logic [DSW-1:0]    stride_ff;

   // latched request
   req_kind_type      kind_ff;
   logic [15:0]       req_size_ff;
   logic [12:0]       req_align_ff;
   logic [31:0]       addr_ff;

   // working registers
   logic [MW-1:0]     prod_ff;
   logic [31:0]       off_ff;
   logic [IW-1:0]     idx_ff;
   logic [IW-1:0]     link_ff;
   status_type        status_ff;
   logic [31:0]       grant_ff;
   logic [15:0]       bytes_ff;

   // divider
   logic [DVW-1:0]    div_quo_ff, div_quo_in;
   logic [DSW-1:0]    div_rem_ff, div_rem_in;
   logic [DSW-1:0]    div_den_ff;
   logic [5:0]        div_cnt_ff;
   div_job_type       div_job_ff;
   logic [DSW:0]      rem_sh;
   logic              rem_ge;

   // output register
   logic              rsp_valid_ff;
   logic [63:0]       rsp_data_ff;
   status_type        rsp_user_ff;

   // link memory
   logic [IW-1:0]     link_mem [MAX_BLOCKS];
   logic [IW-1:0]     rd_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [IW-1:0]     mem_wdata;

   // derived terms
   logic              req_acc, out_free, chk_size, chk_align, head_null;
   logic              div_done, rem_nz, base_lt_end, fr_ok, link_last;
   logic [15:0]       bs4;
   logic [12:0]       aeff;
   logic [DVW-1:0]    base_w, end_w;
   logic [IW-1:0]     count_sat;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign chk_size    = req_size_ff > cfg_bsize_ff;
   assign chk_align   = req_align_ff > cfg_balign_ff;
   assign head_null   = head_ff == NULL_IDX;
   assign div_done    = div_cnt_ff == '0;
   assign rem_nz      = div_rem_ff != '0;
   assign bs4         = (cfg_bsize_ff < 16'd4) ? 16'd4 : cfg_bsize_ff;
   assign aeff        = (cfg_balign_ff == '0) ? 13'd1 : cfg_balign_ff;
   assign base_w      = DVW'(cfg_base_ff)
                        + (rem_nz ? DVW'(DSW'(aeff) - div_rem_ff) : '0);
   assign end_w       = DVW'(cfg_base_ff) + DVW'(cfg_rsize_ff);
   assign base_lt_end = base_w < end_w;
   assign count_sat   = (div_quo_ff > DVW'(MAX_BLOCKS)) ? NULL_IDX : div_quo_ff[IW-1:0];
   assign fr_ok       = (total_ff != '0) && (CMPW'(off_ff) < CMPW'(prod_ff));
   assign link_last   = (link_ff + 1'b1) == total_ff;

   // restoring divider step
   always_comb begin
      rem_sh     = {div_rem_ff, div_quo_ff[DVW-1]};
      rem_ge     = rem_sh >= {1'b0, div_den_ff};
      div_rem_in = rem_ge ? DSW'(rem_sh - {1'b0, div_den_ff}) : DSW'(rem_sh);
      div_quo_in = {div_quo_ff[DVW-2:0], rem_ge};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_acc) state_in = S_DECODE;
         S_DECODE: begin
            case (kind_ff)
               REQ_REBUILD: state_in = S_DIV;
               REQ_ALLOC: begin
                  if (chk_size || chk_align || head_null) state_in = S_RESP;
                  else state_in = S_AL_WAIT;
               end
               REQ_FREE: begin
                  if (chk_size || chk_align) state_in = S_RESP;
                  else state_in = S_FR_CHECK;
               end
               default:     state_in = S_RESP;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               case (div_job_ff)
                  JOB_STRIDE: state_in = S_DIV;
                  JOB_BASE:   state_in = base_lt_end ? S_DIV : S_RESP;
                  JOB_COUNT:  state_in = (count_sat == '0) ? S_RESP : S_RB_LINK;
                  JOB_OFF: begin
                     if (rem_nz) state_in = S_RESP;
                     else if (req_align_ff != '0) state_in = S_DIV;
                     else state_in = S_FR_PUSH;
                  end
                  default:    state_in = rem_nz ? S_RESP : S_FR_PUSH;
               endcase
            end
         end
         S_RB_LINK:  if (link_last) state_in = S_RESP;
         S_AL_WAIT:  state_in = S_AL_ADD;
         S_AL_ADD:   state_in = S_RESP;
         S_FR_CHECK: state_in = fr_ok ? S_DIV : S_RESP;
         S_FR_PUSH:  state_in = S_RESP;
         S_RESP:     if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // link memory write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = link_ff[AW-1:0];
      mem_wdata = link_last ? NULL_IDX : link_ff + 1'b1;
      if (state_ff == S_RB_LINK) begin
         mem_we = 1'b1;
      end else if (state_ff == S_FR_PUSH) begin
         mem_we    = 1'b1;
         mem_waddr = idx_ff[AW-1:0];
         mem_wdata = head_ff;
      end
   end

   // link memory: write, and read the head every cycle
   always_ff @(posedge clock) begin
      if (mem_we) link_mem[mem_waddr] <= mem_wdata;
      rd_ff <= link_mem[head_ff[AW-1:0]];
   end

   // control and pool state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         head_ff       <= NULL_IDX;
         total_ff      <= '0;
         first_ff      <= '0;
         stride_ff     <= '0;
         div_cnt_ff    <= '0;
         cfg_base_ff   <= '0;
         cfg_rsize_ff  <= '0;
         cfg_bsize_ff  <= 16'd16;
         cfg_balign_ff <= 13'd8;
      end else begin
         state_ff <= state_in;

         // take configuration writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_REGION_BASE: cfg_base_ff   <= csr_data;
               CSR_REGION_SIZE: cfg_rsize_ff  <= csr_data[24:0];
               CSR_BLOCK_SIZE:  cfg_bsize_ff  <= csr_data[15:0];
               CSR_BLOCK_ALIGN: cfg_balign_ff <= csr_data[12:0];
               default: ;
            endcase
         end

         // drop the result once taken, unless a new one loads this cycle
         if (rsp_valid_ff && rsp_tready && state_ff != S_RESP) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  kind_ff      <= req_tuser;
                  req_size_ff  <= req_tdata[15:0];
                  req_align_ff <= req_tdata[28:16];
                  addr_ff      <= req_tdata[60:29];
               end
            end
            S_DECODE: begin
               grant_ff  <= '0;
               bytes_ff  <= '0;
               case (kind_ff)
                  REQ_REBUILD: begin
                     status_ff  <= ST_OK;
                     div_quo_ff <= DVW'(bs4);
                     div_rem_ff <= '0;
                     div_den_ff <= DSW'(aeff);
                     div_cnt_ff <= 6'(DIV_STEPS);
                     div_job_ff <= JOB_STRIDE;
                  end
                  REQ_ALLOC, REQ_FREE: begin
                     if (chk_size) status_ff <= ST_SIZE;
                     else if (chk_align) status_ff <= ST_ALIGN;
                     else if (kind_ff == REQ_ALLOC && head_null) status_ff <= ST_EMPTY;
                     else status_ff <= ST_OK;
                     // span of the pool for a free
                     prod_ff <= MW'(stride_ff) * MW'(total_ff);
                     off_ff  <= addr_ff - first_ff;
                  end
                  default: status_ff <= ST_OK;
               endcase
            end
            S_DIV: begin
               if (!div_done) begin
                  div_quo_ff <= div_quo_in;
                  div_rem_ff <= div_rem_in;
                  div_cnt_ff <= div_cnt_ff - 1'b1;
               end else begin
                  case (div_job_ff)
                     JOB_STRIDE: begin
                        stride_ff  <= DSW'(bs4) + (rem_nz ? DSW'(aeff) - div_rem_ff : '0);
                        div_quo_ff <= DVW'(cfg_base_ff);
                        div_rem_ff <= '0;
                        div_den_ff <= DSW'(aeff);
                        div_cnt_ff <= 6'(DIV_STEPS);
                        div_job_ff <= JOB_BASE;
                     end
                     JOB_BASE: begin
                        first_ff <= base_w[31:0];
                        if (base_lt_end) begin
                           div_quo_ff <= end_w - base_w;
                           div_rem_ff <= '0;
                           div_den_ff <= stride_ff;
                           div_cnt_ff <= 6'(DIV_STEPS);
                           div_job_ff <= JOB_COUNT;
                        end else begin
                           total_ff <= '0;
                           head_ff  <= NULL_IDX;
                        end
                     end
                     JOB_COUNT: begin
                        total_ff <= count_sat;
                        head_ff  <= (count_sat == '0) ? NULL_IDX : '0;
                        link_ff  <= '0;
                     end
                     JOB_OFF: begin
                        idx_ff <= div_quo_ff[IW-1:0];
                        if (rem_nz) begin
                           status_ff <= ST_ADDR;
                        end else if (req_align_ff != '0) begin
                           div_quo_ff <= DVW'(addr_ff);
                           div_rem_ff <= '0;
                           div_den_ff <= DSW'(req_align_ff);
                           div_cnt_ff <= 6'(DIV_STEPS);
                           div_job_ff <= JOB_ALIGN;
                        end
                     end
                     default: begin
                        if (rem_nz) status_ff <= ST_ADDR;
                     end
                  endcase
               end
            end
            S_RB_LINK: begin
               link_ff <= link_ff + 1'b1;
            end
            S_AL_WAIT: begin
               // pop: next link becomes the head
               head_ff <= rd_ff;
               prod_ff <= MW'(stride_ff) * MW'(head_ff);
            end
            S_AL_ADD: begin
               grant_ff <= first_ff + 32'(prod_ff);
               bytes_ff <= cfg_bsize_ff;
            end
            S_FR_CHECK: begin
               if (fr_ok) begin
                  div_quo_ff <= DVW'(off_ff);
                  div_rem_ff <= '0;
                  div_den_ff <= stride_ff;
                  div_cnt_ff <= 6'(DIV_STEPS);
                  div_job_ff <= JOB_OFF;
               end else begin
                  status_ff <= ST_ADDR;
               end
            end
            S_FR_PUSH: begin
               head_ff <= idx_ff;
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= status_ff;
                  rsp_data_ff  <= {5'b0, 11'(total_ff), bytes_ff, grant_ff};
               end
            end
            default: ;
         endcase
      end
   end

   // head is a block index or null
   assert property (@(posedge clock) disable iff (reset) head_ff <= NULL_IDX)
      else $error("free-list head out of range");

   // pool never holds more blocks than the link memory
   assert property (@(posedge clock) disable iff (reset) total_ff <= NULL_IDX)
      else $error("block count above pool depth");

   // divider never runs on a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !div_done) |-> div_den_ff != '0)
      else $error("divider started with zero divisor");

   // an accepted item always goes to decode
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");

endmodule

>>> tb/tb_fixed_block_pool_allocator_core.sv
// Testbench for the fixed block pool allocator: random traffic against a free-list predictor.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_core;
   import fbpa_pkg::*;

   localparam int POOL_MAX   = 1024;
   localparam int NULL_IDX   = POOL_MAX;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_LEN   = 400;

   typedef struct packed {
      req_kind_type kind;
      logic [15:0]  size;
      logic [12:0]  align;
      logic [31:0]  addr;
   } pool_req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] grant;
      logic [15:0] bytes;
      logic [10:0] count;
   } pool_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata = '0;
   req_kind_type        req_tuser = REQ_REBUILD;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [63:0]         rsp_tdata;
   status_type          rsp_tuser;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_REGION_BASE;
   logic [31:0]         csr_data = '0;

   fixed_block_pool_allocator_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Register shadows
   logic [31:0] cfg_base  = 32'd0;
   logic [24:0] cfg_size  = 25'd0;
   logic [15:0] cfg_bsize = 16'd16;
   logic [12:0] cfg_align = 13'd8;

   // Predicted pool state
   logic [10:0] link_mem [POOL_MAX];
   logic [10:0] head_idx = 11'(NULL_IDX);
   logic [10:0] pool_blocks = '0;
   logic [32:0] pool_first = '0;
   logic [16:0] pool_stride = '0;

   pool_req_type pending_reqs[$];
   pool_rsp_type expected_rsps[$];
   int  err_count = 0;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_request = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   function automatic longint unsigned round_to(input longint unsigned x,
                                                input longint unsigned a);
      longint unsigned m;
      m = (a == 0) ? 1 : a;
      return ((x + m - 1) / m) * m;
   endfunction

   // Block geometry for the current registers
   function automatic void pool_layout(output longint unsigned first,
                                       output longint unsigned stride,
                                       output longint unsigned count);
      longint unsigned bs, lim;
      bs     = (cfg_bsize < 4) ? 4 : cfg_bsize;
      stride = round_to(bs, cfg_align);
      first  = round_to(cfg_base, cfg_align);
      lim    = longint'(cfg_base) + longint'(cfg_size);
      count  = (first < lim) ? (lim - first) / stride : 0;
      if (count > POOL_MAX) count = POOL_MAX;
   endfunction

   // Apply one request to the predicted pool and return its result
   function automatic pool_rsp_type pool_apply(input pool_req_type r);
      pool_rsp_type    o;
      longint unsigned first, stride, count, span, off;
      bit              ok;
      int              idx;
      o = '0;
      o.status = ST_OK;
      if (r.kind == REQ_REBUILD) begin
         pool_layout(first, stride, count);
         pool_first  = first[32:0];
         pool_stride = stride[16:0];
         pool_blocks = count[10:0];
         for (int i = 0; i < count; i++)
            link_mem[i] = (i + 1 < count) ? 11'(i + 1) : 11'(NULL_IDX);
         head_idx = (count != 0) ? 11'd0 : 11'(NULL_IDX);
      end else if (r.kind == REQ_ALLOC || r.kind == REQ_FREE) begin
         if (r.size > cfg_bsize) begin
            o.status = ST_SIZE;
         end else if (r.align > cfg_align) begin
            o.status = ST_ALIGN;
         end else if (r.kind == REQ_ALLOC) begin
            if (head_idx >= NULL_IDX) begin
               o.status = ST_EMPTY;
            end else begin
               o.grant  = 32'(longint'(pool_first) + longint'(pool_stride) * head_idx);
               o.bytes  = cfg_bsize;
               head_idx = link_mem[head_idx];
            end
         end else begin
            first = pool_first[31:0];
            span  = longint'(pool_stride) * pool_blocks;
            off   = (longint'(r.addr) - first) & 64'hFFFF_FFFF;
            ok    = pool_blocks != 0 && pool_stride != 0 && off < span;
            if (ok && off % pool_stride != 0) ok = 0;
            if (ok && r.align != 0 && r.addr % r.align != 0) ok = 0;
            if (!ok) begin
               o.status = ST_ADDR;
            end else begin
               idx = int'(off / pool_stride);
               if (idx < NULL_IDX) begin
                  link_mem[idx] = head_idx;
                  head_idx      = 11'(idx);
               end
            end
         end
      end
      o.count = pool_blocks;
      return o;
   endfunction

   // Driver: predict each accepted item, then offer the next one
   always @(posedge clock) begin
      pool_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(pool_apply({req_tuser, req_tdata[15:0],
                                                req_tdata[28:16], req_tdata[60:29]}));
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_tuser  <= nxt.kind;
               req_tdata  <= {3'b000, nxt.addr, nxt.align, nxt.size};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_LEN;
         hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      pool_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tuser != want.status)
               report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[31:0] != want.grant)
               report_mismatch("grant_address", rsp_tdata[31:0], want.grant);
            if (rsp_tdata[47:32] != want.bytes)
               report_mismatch("grant_bytes", rsp_tdata[47:32], want.bytes);
            if (rsp_tdata[58:48] != want.count)
               report_mismatch("block_count", rsp_tdata[58:48], want.count);
         end
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_REGION_BASE: cfg_base  = val;
         CSR_REGION_SIZE: cfg_size  = val[24:0];
         CSR_BLOCK_SIZE:  cfg_bsize = val[15:0];
         CSR_BLOCK_ALIGN: cfg_align = val[12:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] base, input logic [31:0] len,
                            input logic [31:0] bsize, input logic [31:0] algn);
      write_reg(CSR_REGION_BASE, base);
      write_reg(CSR_REGION_SIZE, len);
      write_reg(CSR_BLOCK_SIZE, bsize);
      write_reg(CSR_BLOCK_ALIGN, algn);
   endtask

   task automatic add_req(input req_kind_type k, input int unsigned sz,
                          input int unsigned al, input logic [31:0] ad);
      pool_req_type r;
      r.kind  = k;
      r.size  = 16'(sz);
      r.align = 13'(al);
      r.addr  = ad;
      pending_reqs.push_back(r);
   endtask

   // Hold until every item has gone through and the block is quiet
   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0);
      repeat (80) @(posedge clock);
   endtask

   // An alignment that passes the current block_align check
   function automatic int unsigned fitting_align();
      int unsigned a;
      if (cfg_align == 0 || $urandom_range(7) == 0) return 0;
      a = 1 << $urandom_range(12);
      while (a > cfg_align) a = a >> 1;
      return a;
   endfunction

   // Mostly well-formed allocate and free traffic for the current layout
   task automatic add_traffic(input int n);
      longint unsigned first, stride, count, a;
      int unsigned     pick, al;
      pool_layout(first, stride, count);
      add_req(REQ_REBUILD, $urandom, $urandom, $urandom);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            add_req(REQ_ALLOC, $urandom_range(cfg_bsize), fitting_align(), $urandom);
         end else if (pick < 80 && count != 0) begin
            al = fitting_align();
            a  = first + stride * $urandom_range(int'(count) - 1);
            if ($urandom_range(9) == 0) a = a + $urandom_range(1, int'(stride) - 1);
            add_req(REQ_FREE, $urandom_range(cfg_bsize), al, 32'(a));
         end else if (pick < 83) begin
            add_req(REQ_REBUILD, $urandom, $urandom, $urandom);
         end else begin
            add_req(req_kind_type'($urandom_range(3)), $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      int unsigned send_pcts [4] = '{0, 61, 0, 25};
      int unsigned stall_pcts[4] = '{0, 0, 61, 25};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty pool after reset, unknown kind, error checks
      add_req(REQ_ALLOC, 0, 0, 0);
      add_req(REQ_FREE, 16, 8, 0);
      add_req(2'd3, 16'hFFFF, 13'h1FFF, 32'hFFFF_FFFF);
      add_req(REQ_REBUILD, 0, 0, 0);
      add_req(REQ_ALLOC, 17, 1, 0);
      add_req(REQ_ALLOC, 16, 16, 0);
      add_req(REQ_FREE, 65535, 8191, 32'hFFFF_FFFF);
      drain();

      // Tiny block size, unaligned base, error cases for free
      configure(32'h0000_1003, 4096, 3, 16);
      add_req(REQ_REBUILD, 0, 0, 0);
      add_req(REQ_ALLOC, 3, 16, 0);
      add_req(REQ_ALLOC, 0, 0, 0);
      add_req(REQ_FREE, 3, 16, 32'h0000_1010);
      add_req(REQ_FREE, 0, 0, 32'h0000_1000);
      add_req(REQ_FREE, 0, 0, 32'h0000_1011);
      add_req(REQ_FREE, 0, 0, 32'h0000_2010);
      add_req(REQ_FREE, 0, 16, 32'h0000_1020);
      add_req(REQ_FREE, 0, 0, 32'h0000_1020);
      add_req(REQ_FREE, 0, 0, 32'h0000_1020);
      add_req(REQ_ALLOC, 0, 0, 0);
      add_req(REQ_ALLOC, 4, 1, 0);
      drain();

      // Random phases, from the extremes to odd alignments
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: configure(0, 32'h0100_0000, 4, 1);
            1: configure(32'hFFFF_F000, 32'h0002_0000, 65535, 4096);
            2: configure(5, 1000, 30, 12);
            3: configure(77, 5000, 100, 0);
            4: configure(32'hFFFF_FFFF, 32'h01FF_FFFF, 16'hFFFF, 13'h1FFF);
            5: configure(32'h1234_5678, 2000, 8, 8);
            6: configure(0, 0, 16, 8);
            default: configure($urandom, $urandom_range(4096), $urandom_range(4, 200),
                               1 << $urandom_range(6));
         endcase
         send_idle_pct = send_pcts[ph % 4];
         rsp_stall_pct = stall_pcts[ph % 4];
         if (ph == 4) hold_request = 1;
         add_traffic(145);
         drain();
      end

      if (err_count == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
